/* hw/rtl/hold_to_confirm_gesture_fsm_core_defines.svh */
// Assertion macros shared by the hold-to-confirm gesture engine RTL.
`ifndef HOLD_TO_CONFIRM_GESTURE_FSM_CORE_DEFINES_SVH
`define HOLD_TO_CONFIRM_GESTURE_FSM_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define HCG_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("hcg assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define HCG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hcg assertion failed");

`endif

/* hw/rtl/hcg_pkg.sv */
// Types and constants shared by the hold-to-confirm gesture engine.
`default_nettype none

package hcg_pkg;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_END,
      KIND_TICK,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PREROLL,
      PH_COUNTING,
      PH_FIRING,
      PH_DONE,
      PH_ABORTED
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EVAL,
      SEQ_DIV,
      SEQ_RESP
   } seq_state_type;

   typedef enum logic [2:0] {
      REG_PREROLL,
      REG_BAR,
      REG_DONE,
      REG_KEY_UP,
      REG_KEY_DOWN,
      REG_KEY_LEFT,
      REG_KEY_RIGHT
   } reg_index_type;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_PROG   = 3'd1;
   localparam logic [2:0] ACT_REBOOT = 3'd2;
   localparam logic [2:0] ACT_MAX    = 3'd4;

   localparam logic [2:0] BTN_SELECT = 3'd0;
   localparam logic [2:0] BTN_UP     = 3'd1;
   localparam logic [2:0] BTN_DOWN   = 3'd2;
   localparam logic [2:0] BTN_LEFT   = 3'd3;
   localparam logic [2:0] BTN_RIGHT  = 3'd4;

   localparam logic [15:0] PREROLL_RESET = 16'd500;
   localparam logic [15:0] BAR_RESET     = 16'd3000;
   localparam logic [15:0] DONE_RESET    = 16'd1000;

   localparam int MS_BITS    = 16;
   localparam int ACT_BITS   = 3;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   typedef struct packed {
      logic [MS_BITS-1:0]  preroll_ms;
      logic [MS_BITS-1:0]  bar_ms;
      logic [MS_BITS-1:0]  done_ms;
      logic [ACT_BITS-1:0] key_up_action;
      logic [ACT_BITS-1:0] key_down_action;
      logic [ACT_BITS-1:0] key_left_action;
      logic [ACT_BITS-1:0] key_right_action;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/hold_to_confirm_gesture_fsm_core.sv */
// Top level of the hold-to-confirm gesture engine.
// Requests enter on the req_ channel (valid/ready): start hold, end hold,
// tick with a wrapping millisecond timestamp, or clear to idle. Every request
// gives exactly one response on the rsp_ channel (valid/ready) with the phase,
// live action, fired action, remaining bar fraction and countdown seconds.
// The block takes one request at a time and drops req_ready until the
// response has been taken. A request is evaluated in the cycle after it is
// accepted; the response is presented in the RESP state, entered from EVAL, or
// from DIV when the bar is partly empty and the fraction comes from the
// bit-serial divider, one quotient bit a cycle. A stalled response holds
// steady and no new request is taken.
// Reset returns the gesture to idle and loads the default timing registers;
// the APB-style port writes the registers and should be used only when idle.
`default_nettype none

`include "hold_to_confirm_gesture_fsm_core_defines.svh"

module hold_to_confirm_gesture_fsm_core #(
   parameter int TIME_BITS     = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic [2:0]                    req_button,
   input  wire logic                          req_on_home,
   input  wire logic [31:0]                   req_now_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [2:0]                    rsp_phase,
   output logic      [2:0]                    rsp_current_action,
   output logic      [2:0]                    rsp_fired_action,
   output logic      [FRACTION_BITS:0]        rsp_bar_fraction,
   output logic      [1:0]                    rsp_seconds_left,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [hcg_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [hcg_pkg::DATA_BITS-1:0] pwdata,
   output logic      [hcg_pkg::DATA_BITS-1:0] prdata,
   output logic                               pready
);

   localparam int SUM_W = TIME_BITS + 1;
   localparam logic [FRACTION_BITS:0] FRAC_FULL = {1'b1, {FRACTION_BITS{1'b0}}};

   hcg_pkg::cfg_type       cfg;
   hcg_pkg::seq_state_type seq_ff;
   hcg_pkg::seq_state_type seq_in;
   hcg_pkg::phase_type     phase_ff;
   hcg_pkg::phase_type     phase_in;

   logic [2:0]             action_ff;
   logic [2:0]             action_in;
   logic                   holding_ff;
   logic                   holding_in;
   logic                   pending_ff;
   logic                   pending_in;
   logic                   fired_flag_ff;
   logic                   fired_flag_in;
   logic [TIME_BITS-1:0]   hold_start_ff;
   logic [TIME_BITS-1:0]   hold_start_in;
   logic [TIME_BITS-1:0]   elapsed_ff;
   logic [TIME_BITS-1:0]   elapsed_in;
   logic [TIME_BITS-1:0]   fired_time_ff;
   logic [TIME_BITS-1:0]   fired_time_in;
   logic [2:0]             fired_out_ff;
   logic [2:0]             fired_out_in;
   logic [FRACTION_BITS:0] frac_ff;
   logic [FRACTION_BITS:0] frac_in;
   logic [1:0]             secs_ff;
   logic [1:0]             secs_in;

   logic                   accept;
   logic                   div_start;
   logic                   div_done;
   logic [FRACTION_BITS:0] div_quotient;
   logic [2:0]             resolved;
   logic [2:0]             key_action;
   logic [TIME_BITS-1:0]   now_t;
   logic [TIME_BITS-1:0]   tick_start;
   logic [TIME_BITS-1:0]   tick_elapsed;
   logic [SUM_W-1:0]       limit_ext;
   logic [SUM_W-1:0]       elapsed_ext;
   logic [15:0]            remaining;
   logic [17:0]            rem_x3;
   logic                   need_div;
   logic [FRACTION_BITS:0] eval_frac;
   logic [1:0]             eval_secs;

   hcg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hcg_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (remaining),
      .denom    (cfg.bar_ms),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign accept       = req_valid && req_ready;
   assign now_t        = TIME_BITS'(req_now_ms);
   assign tick_start   = pending_ff ? now_t : hold_start_ff;
   assign tick_elapsed = now_t - tick_start;
   assign limit_ext    = SUM_W'(cfg.preroll_ms) + SUM_W'(cfg.bar_ms);

   always_comb begin
      case (req_button)
         hcg_pkg::BTN_UP:    key_action = cfg.key_up_action;
         hcg_pkg::BTN_DOWN:  key_action = cfg.key_down_action;
         hcg_pkg::BTN_LEFT:  key_action = cfg.key_left_action;
         hcg_pkg::BTN_RIGHT: key_action = cfg.key_right_action;
         default:            key_action = hcg_pkg::ACT_NONE;
      endcase
      if (req_button == hcg_pkg::BTN_SELECT) begin
         resolved = hcg_pkg::ACT_PROG;
      end else if (!req_on_home || key_action > hcg_pkg::ACT_MAX) begin
         resolved = hcg_pkg::ACT_NONE;
      end else begin
         resolved = key_action;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      action_in     = action_ff;
      holding_in    = holding_ff;
      pending_in    = pending_ff;
      fired_flag_in = fired_flag_ff;
      hold_start_in = hold_start_ff;
      elapsed_in    = elapsed_ff;
      fired_time_in = fired_time_ff;
      fired_out_in  = fired_out_ff;
      if (accept) begin
         fired_out_in = hcg_pkg::ACT_NONE;
         case (hcg_pkg::kind_type'(req_action))
            hcg_pkg::KIND_START: begin
               if (!holding_ff && phase_ff == hcg_pkg::PH_IDLE &&
                   resolved != hcg_pkg::ACT_NONE) begin
                  action_in     = resolved;
                  phase_in      = hcg_pkg::PH_PREROLL;
                  holding_in    = 1'b1;
                  pending_in    = 1'b1;
                  hold_start_in = '0;
                  elapsed_in    = '0;
                  fired_flag_in = 1'b0;
                  fired_time_in = '0;
               end
            end
            hcg_pkg::KIND_END: begin
               if (holding_ff) begin
                  holding_in = 1'b0;
                  if (phase_ff == hcg_pkg::PH_PREROLL || phase_ff == hcg_pkg::PH_COUNTING) begin
                     phase_in  = hcg_pkg::PH_ABORTED;
                     action_in = hcg_pkg::ACT_NONE;
                  end
               end
            end
            hcg_pkg::KIND_TICK: begin
               hold_start_in = tick_start;
               pending_in    = 1'b0;
               case (phase_ff)
                  hcg_pkg::PH_PREROLL: begin
                     elapsed_in = tick_elapsed;
                     if (tick_elapsed >= TIME_BITS'(cfg.preroll_ms)) begin
                        phase_in = hcg_pkg::PH_COUNTING;
                     end
                  end
                  hcg_pkg::PH_COUNTING: begin
                     elapsed_in = tick_elapsed;
                     if (SUM_W'(tick_elapsed) >= limit_ext) begin
                        phase_in      = hcg_pkg::PH_FIRING;
                        fired_time_in = now_t;
                        if (!fired_flag_ff) begin
                           fired_flag_in = 1'b1;
                           fired_out_in  = action_ff;
                        end
                     end
                  end
                  hcg_pkg::PH_FIRING: begin
                     if (action_ff != hcg_pkg::ACT_REBOOT &&
                         (now_t - fired_time_ff) >= TIME_BITS'(cfg.done_ms)) begin
                        phase_in = hcg_pkg::PH_DONE;
                     end
                  end
                  hcg_pkg::PH_DONE, hcg_pkg::PH_ABORTED: begin
                     phase_in  = hcg_pkg::PH_IDLE;
                     action_in = hcg_pkg::ACT_NONE;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in      = hcg_pkg::PH_IDLE;
               action_in     = hcg_pkg::ACT_NONE;
               holding_in    = 1'b0;
               pending_in    = 1'b0;
               hold_start_in = '0;
               elapsed_in    = '0;
               fired_flag_in = 1'b0;
               fired_time_in = '0;
            end
         endcase
      end
   end

   assign elapsed_ext = SUM_W'(elapsed_ff);
   assign remaining   = 16'(limit_ext - elapsed_ext);
   assign rem_x3      = {1'b0, remaining, 1'b0} + {2'b00, remaining};

   always_comb begin
      need_div  = 1'b0;
      eval_frac = '0;
      eval_secs = 2'd0;
      if (phase_ff == hcg_pkg::PH_PREROLL) begin
         eval_frac = FRAC_FULL;
         eval_secs = 2'd3;
      end else if (phase_ff == hcg_pkg::PH_COUNTING) begin
         if (elapsed_ff <= TIME_BITS'(cfg.preroll_ms)) begin
            eval_frac = FRAC_FULL;
            eval_secs = 2'd3;
         end else if (elapsed_ext < limit_ext) begin
            need_div = 1'b1;
            if (rem_x3 <= 18'(cfg.bar_ms)) begin
               eval_secs = 2'd1;
            end else if (rem_x3 <= {1'b0, cfg.bar_ms, 1'b0}) begin
               eval_secs = 2'd2;
            end else begin
               eval_secs = 2'd3;
            end
         end
      end
   end

   always_comb begin
      frac_in = frac_ff;
      secs_in = secs_ff;
      if (seq_ff == hcg_pkg::SEQ_EVAL) begin
         frac_in = eval_frac;
         secs_in = eval_secs;
      end else if (seq_ff == hcg_pkg::SEQ_DIV && div_done) begin
         frac_in = div_quotient;
      end
   end

   always_comb begin
      case (seq_ff)
         hcg_pkg::SEQ_IDLE: seq_in = req_valid ? hcg_pkg::SEQ_EVAL : hcg_pkg::SEQ_IDLE;
         hcg_pkg::SEQ_EVAL: seq_in = need_div ? hcg_pkg::SEQ_DIV : hcg_pkg::SEQ_RESP;
         hcg_pkg::SEQ_DIV:  seq_in = div_done ? hcg_pkg::SEQ_RESP : hcg_pkg::SEQ_DIV;
         hcg_pkg::SEQ_RESP: seq_in = rsp_ready ? hcg_pkg::SEQ_IDLE : hcg_pkg::SEQ_RESP;
         default:           seq_in = hcg_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      case (seq_ff)
         hcg_pkg::SEQ_IDLE: req_ready = 1'b1;
         hcg_pkg::SEQ_EVAL: div_start = need_div;
         hcg_pkg::SEQ_RESP: rsp_valid = 1'b1;
         default:           req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= hcg_pkg::SEQ_IDLE;
         phase_ff      <= hcg_pkg::PH_IDLE;
         action_ff     <= hcg_pkg::ACT_NONE;
         holding_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         fired_flag_ff <= 1'b0;
         hold_start_ff <= '0;
         elapsed_ff    <= '0;
         fired_time_ff <= '0;
         fired_out_ff  <= hcg_pkg::ACT_NONE;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         action_ff     <= action_in;
         holding_ff    <= holding_in;
         pending_ff    <= pending_in;
         fired_flag_ff <= fired_flag_in;
         hold_start_ff <= hold_start_in;
         elapsed_ff    <= elapsed_in;
         fired_time_ff <= fired_time_in;
         fired_out_ff  <= fired_out_in;
      end
      frac_ff <= frac_in;
      secs_ff <= secs_in;
   end

   assign rsp_phase          = phase_ff;
   assign rsp_current_action = action_ff;
   assign rsp_fired_action   = fired_out_ff;
   assign rsp_bar_fraction   = frac_ff;
   assign rsp_seconds_left   = secs_ff;

   `HCG_ASSERT_NEXT(a_accept_leaves_idle, accept, !req_ready)
   `HCG_ASSERT(a_fire_only_in_firing, rsp_valid |->
      (rsp_fired_action == hcg_pkg::ACT_NONE || rsp_phase == hcg_pkg::PH_FIRING))
   `HCG_ASSERT(a_bar_empty_when_inactive,
      (rsp_valid && rsp_phase != hcg_pkg::PH_PREROLL && rsp_phase != hcg_pkg::PH_COUNTING) |->
      (rsp_bar_fraction == '0 && rsp_seconds_left == 2'd0))
   `HCG_ASSERT(a_div_done_in_div_state, div_done |-> (seq_ff == hcg_pkg::SEQ_DIV))

endmodule

`default_nettype wire

/* hw/rtl/hcg_csr.sv */
// Configuration register file with an APB-style access port.
`default_nettype none

module hcg_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [hcg_pkg::ADDR_BITS-1:0]    paddr,
   input  wire logic [hcg_pkg::DATA_BITS-1:0]    pwdata,
   output logic      [hcg_pkg::DATA_BITS-1:0]    prdata,
   output logic                                  pready,
   output hcg_pkg::cfg_type                      cfg
);

   hcg_pkg::cfg_type      cfg_ff;
   hcg_pkg::cfg_type      cfg_in;
   hcg_pkg::reg_index_type index;
   logic                  write_en;

   assign index    = hcg_pkg::reg_index_type'(paddr[4:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            hcg_pkg::REG_PREROLL:   cfg_in.preroll_ms       = pwdata[15:0];
            hcg_pkg::REG_BAR:       cfg_in.bar_ms           = pwdata[15:0];
            hcg_pkg::REG_DONE:      cfg_in.done_ms          = pwdata[15:0];
            hcg_pkg::REG_KEY_UP:    cfg_in.key_up_action    = pwdata[2:0];
            hcg_pkg::REG_KEY_DOWN:  cfg_in.key_down_action  = pwdata[2:0];
            hcg_pkg::REG_KEY_LEFT:  cfg_in.key_left_action  = pwdata[2:0];
            hcg_pkg::REG_KEY_RIGHT: cfg_in.key_right_action = pwdata[2:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         hcg_pkg::REG_PREROLL:   prdata = {16'd0, cfg_ff.preroll_ms};
         hcg_pkg::REG_BAR:       prdata = {16'd0, cfg_ff.bar_ms};
         hcg_pkg::REG_DONE:      prdata = {16'd0, cfg_ff.done_ms};
         hcg_pkg::REG_KEY_UP:    prdata = {29'd0, cfg_ff.key_up_action};
         hcg_pkg::REG_KEY_DOWN:  prdata = {29'd0, cfg_ff.key_down_action};
         hcg_pkg::REG_KEY_LEFT:  prdata = {29'd0, cfg_ff.key_left_action};
         hcg_pkg::REG_KEY_RIGHT: prdata = {29'd0, cfg_ff.key_right_action};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preroll_ms       <= hcg_pkg::PREROLL_RESET;
         cfg_ff.bar_ms           <= hcg_pkg::BAR_RESET;
         cfg_ff.done_ms          <= hcg_pkg::DONE_RESET;
         cfg_ff.key_up_action    <= hcg_pkg::ACT_NONE;
         cfg_ff.key_down_action  <= hcg_pkg::ACT_NONE;
         cfg_ff.key_left_action  <= hcg_pkg::ACT_NONE;
         cfg_ff.key_right_action <= hcg_pkg::ACT_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/hcg_div.sv */
// Bit-serial restoring divider that produces the ceiling of a bar fraction.
`default_nettype none

`include "hold_to_confirm_gesture_fsm_core_defines.svh"

module hcg_div #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [hcg_pkg::MS_BITS-1:0] numer,
   input  wire logic [hcg_pkg::MS_BITS-1:0] denom,
   output logic                            done,
   output logic      [FRACTION_BITS:0]     quotient
);

   localparam int CNT_W = $clog2(FRACTION_BITS + 1);

   logic [hcg_pkg::MS_BITS:0]   rem_ff;
   logic [hcg_pkg::MS_BITS:0]   rem_in;
   logic [FRACTION_BITS-1:0]    quo_ff;
   logic [FRACTION_BITS-1:0]    quo_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        busy_ff;
   logic                        busy_in;
   logic                        done_ff;
   logic                        done_in;
   logic [hcg_pkg::MS_BITS:0]   shifted;
   logic [hcg_pkg::MS_BITS:0]   denom_ext;
   logic                        fits;

   assign shifted   = {rem_ff[hcg_pkg::MS_BITS-1:0], 1'b0};
   assign denom_ext = {1'b0, denom};
   assign fits      = shifted >= denom_ext;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = {1'b0, numer};
         quo_in   = '0;
         count_in = CNT_W'(FRACTION_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? (shifted - denom_ext) : shifted;
         quo_in   = {quo_ff[FRACTION_BITS-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = {1'b0, quo_ff} + (FRACTION_BITS + 1)'(rem_ff != '0);

   `HCG_ASSERT(a_done_when_busy_ends, $fell(busy_ff) |-> done_ff)
   `HCG_ASSERT_NEXT(a_done_single_pulse, done_ff, !done_ff)
   `HCG_ASSERT(a_rem_below_denom, busy_ff |-> (rem_ff < denom_ext))

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the hold-to-confirm gesture engine top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 16;
   localparam logic [2:0] ACT_PAUSE = 3'd3;
   localparam logic [2:0] ACT_DISPLAY_OFF = 3'd4;
   localparam int STALL_NONE = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_BURSTY = 2;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1825;
   localparam int SETTING_COUNT = 8;

   typedef struct {
      hcg_pkg::phase_type phase;
      logic [2:0] current_action;
      logic [2:0] fired_action;
      logic [FRAC_BITS:0] bar_fraction;
      logic [1:0] seconds_left;
   } gesture_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = 2'd0;
   logic [2:0] req_button = 3'd0;
   logic req_on_home = 1'b0;
   logic [31:0] req_now_ms = 32'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_phase;
   logic [2:0] rsp_current_action;
   logic [2:0] rsp_fired_action;
   logic [FRAC_BITS:0] rsp_bar_fraction;
   logic [1:0] rsp_seconds_left;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [hcg_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [hcg_pkg::DATA_BITS-1:0] pwdata = '0;
   logic [hcg_pkg::DATA_BITS-1:0] prdata;
   logic pready;

   hold_to_confirm_gesture_fsm_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_button(req_button),
      .req_on_home(req_on_home),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_phase(rsp_phase),
      .rsp_current_action(rsp_current_action),
      .rsp_fired_action(rsp_fired_action),
      .rsp_bar_fraction(rsp_bar_fraction),
      .rsp_seconds_left(rsp_seconds_left),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Register copies and gesture state mirrored by the predictor.
   logic [15:0] cfg_preroll = hcg_pkg::PREROLL_RESET;
   logic [15:0] cfg_bar = hcg_pkg::BAR_RESET;
   logic [15:0] cfg_done = hcg_pkg::DONE_RESET;
   logic [2:0] cfg_key_up = hcg_pkg::ACT_NONE;
   logic [2:0] cfg_key_down = hcg_pkg::ACT_NONE;
   logic [2:0] cfg_key_left = hcg_pkg::ACT_NONE;
   logic [2:0] cfg_key_right = hcg_pkg::ACT_NONE;

   hcg_pkg::phase_type gst_phase = hcg_pkg::PH_IDLE;
   logic [2:0] gst_action = hcg_pkg::ACT_NONE;
   bit gst_holding = 1'b0;
   bit gst_start_pending = 1'b0;
   bit gst_fired = 1'b0;
   logic [31:0] gst_hold_start = '0;
   logic [31:0] gst_elapsed = '0;
   logic [31:0] gst_fired_time = '0;

   gesture_status_type status_q[$];
   int errors = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int register_writes = 0;
   int fired_count = 0;
   int abort_count = 0;
   int partial_bar_count = 0;
   int burst_left = 0;
   int gap_max = 0;
   int stall_mode = STALL_NONE;
   int stall_left = 0;
   int idle_cycles = 0;
   logic [31:0] clock_ms = '0;

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40)
         $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   function automatic logic [2:0] resolve_action(input logic [2:0] button,
                                                 input logic on_home);
      logic [2:0] act;
      act = hcg_pkg::ACT_NONE;
      if (button == hcg_pkg::BTN_SELECT)
         return hcg_pkg::ACT_PROG;
      if (!on_home)
         return hcg_pkg::ACT_NONE;
      case (button)
         hcg_pkg::BTN_UP: act = cfg_key_up;
         hcg_pkg::BTN_DOWN: act = cfg_key_down;
         hcg_pkg::BTN_LEFT: act = cfg_key_left;
         hcg_pkg::BTN_RIGHT: act = cfg_key_right;
         default: act = hcg_pkg::ACT_NONE;
      endcase
      return (act > hcg_pkg::ACT_MAX) ? hcg_pkg::ACT_NONE : act;
   endfunction

   function automatic gesture_status_type step_gesture(input hcg_pkg::kind_type kind,
                                                       input logic [2:0] button,
                                                       input logic on_home,
                                                       input logic [31:0] now);
      gesture_status_type s;
      logic [2:0] act;
      logic [31:0] since_fire;
      logic [63:0] fire_point;
      longint unsigned over, rem, frac, secs;
      s.fired_action = hcg_pkg::ACT_NONE;
      frac = 0;
      secs = 0;
      case (kind)
         hcg_pkg::KIND_START: begin
            act = resolve_action(button, on_home);
            if (!gst_holding && gst_phase == hcg_pkg::PH_IDLE && act != hcg_pkg::ACT_NONE) begin
               gst_action = act;
               gst_phase = hcg_pkg::PH_PREROLL;
               gst_holding = 1'b1;
               gst_start_pending = 1'b1;
               gst_hold_start = '0;
               gst_elapsed = '0;
               gst_fired = 1'b0;
               gst_fired_time = '0;
            end
         end
         hcg_pkg::KIND_END: begin
            if (gst_holding) begin
               gst_holding = 1'b0;
               if (gst_phase == hcg_pkg::PH_PREROLL || gst_phase == hcg_pkg::PH_COUNTING) begin
                  gst_phase = hcg_pkg::PH_ABORTED;
                  gst_action = hcg_pkg::ACT_NONE;
                  abort_count++;
               end
            end
         end
         hcg_pkg::KIND_TICK: begin
            if (gst_start_pending) begin
               gst_hold_start = now;
               gst_start_pending = 1'b0;
            end
            case (gst_phase)
               hcg_pkg::PH_PREROLL: begin
                  gst_elapsed = now - gst_hold_start;
                  if (gst_elapsed >= cfg_preroll)
                     gst_phase = hcg_pkg::PH_COUNTING;
               end
               hcg_pkg::PH_COUNTING: begin
                  gst_elapsed = now - gst_hold_start;
                  fire_point = 64'(cfg_preroll) + 64'(cfg_bar);
                  if (64'(gst_elapsed) >= fire_point) begin
                     gst_phase = hcg_pkg::PH_FIRING;
                     gst_fired_time = now;
                     if (!gst_fired) begin
                        gst_fired = 1'b1;
                        s.fired_action = gst_action;
                        fired_count++;
                     end
                  end
               end
               hcg_pkg::PH_FIRING: begin
                  since_fire = now - gst_fired_time;
                  if (gst_action != hcg_pkg::ACT_REBOOT && since_fire >= cfg_done)
                     gst_phase = hcg_pkg::PH_DONE;
               end
               hcg_pkg::PH_DONE, hcg_pkg::PH_ABORTED: begin
                  gst_phase = hcg_pkg::PH_IDLE;
                  gst_action = hcg_pkg::ACT_NONE;
               end
               default: ;
            endcase
         end
         default: begin
            gst_phase = hcg_pkg::PH_IDLE;
            gst_action = hcg_pkg::ACT_NONE;
            gst_holding = 1'b0;
            gst_start_pending = 1'b0;
            gst_hold_start = '0;
            gst_elapsed = '0;
            gst_fired = 1'b0;
            gst_fired_time = '0;
         end
      endcase

      if (gst_phase == hcg_pkg::PH_PREROLL) begin
         frac = 64'd1 << FRAC_BITS;
         secs = 3;
      end else if (gst_phase == hcg_pkg::PH_COUNTING) begin
         if (gst_elapsed <= cfg_preroll) begin
            frac = 64'd1 << FRAC_BITS;
            secs = 3;
         end else begin
            over = 64'(gst_elapsed) - 64'(cfg_preroll);
            if (over < 64'(cfg_bar)) begin
               rem = 64'(cfg_bar) - over;
               frac = ((rem << FRAC_BITS) + cfg_bar - 1) / cfg_bar;
               secs = (3 * rem + cfg_bar - 1) / cfg_bar;
               if (secs < 1) secs = 1;
               if (secs > 3) secs = 3;
               partial_bar_count++;
            end
         end
      end

      s.phase = gst_phase;
      s.current_action = gst_action;
      s.bar_fraction = frac[FRAC_BITS:0];
      s.seconds_left = secs[1:0];
      return s;
   endfunction

   task automatic drain_responses();
      req_valid = 1'b0;
      while (status_q.size() != 0)
         @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input hcg_pkg::kind_type kind, input logic [2:0] button,
                               input logic on_home, input logic [31:0] now);
      int gap;
      if ($urandom_range(0, 99) == 0)
         drain_responses();
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_action = kind;
      req_button = button;
      req_on_home = on_home;
      req_now_ms = now;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      status_q.push_back(step_gesture(kind, button, on_home, now));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input hcg_pkg::reg_index_type idx, input logic [31:0] value);
      req_valid = 1'b0;
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      case (idx)
         hcg_pkg::REG_PREROLL: cfg_preroll = value[15:0];
         hcg_pkg::REG_BAR: cfg_bar = value[15:0];
         hcg_pkg::REG_DONE: cfg_done = value[15:0];
         hcg_pkg::REG_KEY_UP: cfg_key_up = value[2:0];
         hcg_pkg::REG_KEY_DOWN: cfg_key_down = value[2:0];
         hcg_pkg::REG_KEY_LEFT: cfg_key_left = value[2:0];
         default: cfg_key_right = value[2:0];
      endcase
      register_writes++;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] preroll, input logic [15:0] bar,
                                 input logic [15:0] done_time, input logic [2:0] up,
                                 input logic [2:0] down, input logic [2:0] left,
                                 input logic [2:0] right);
      drain_responses();
      write_register(hcg_pkg::REG_PREROLL, 32'(preroll));
      write_register(hcg_pkg::REG_BAR, 32'(bar));
      write_register(hcg_pkg::REG_DONE, 32'(done_time));
      write_register(hcg_pkg::REG_KEY_UP, 32'(up));
      write_register(hcg_pkg::REG_KEY_DOWN, 32'(down));
      write_register(hcg_pkg::REG_KEY_LEFT, 32'(left));
      write_register(hcg_pkg::REG_KEY_RIGHT, 32'(right));
   endtask

   function automatic logic [2:0] random_key_action();
      return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
   endfunction

   // One gesture: an optional release of a stale hold, a start request, then
   // mostly ticks with occasional releases, restarts and clears.
   task automatic run_gesture();
      logic [2:0] button;
      logic on_home;
      int steps;
      int r;
      int unsigned span;
      span = cfg_preroll + cfg_bar + cfg_done + 2;
      if (gst_holding && $urandom_range(0, 9) != 0)
         send_request(hcg_pkg::KIND_END, 3'($urandom), 1'($urandom), $urandom);
      r = $urandom_range(0, 9);
      if (r < 4) begin
         button = hcg_pkg::BTN_SELECT;
         on_home = 1'($urandom);
      end else if (r < 8) begin
         button = hcg_pkg::BTN_UP + 3'($urandom_range(0, 3));
         on_home = ($urandom_range(0, 4) != 0);
      end else begin
         button = 3'($urandom_range(0, 7));
         on_home = 1'($urandom);
      end
      send_request(hcg_pkg::KIND_START, button, on_home, $urandom);
      steps = 0;
      while (steps < 80 && !(gst_phase == hcg_pkg::PH_IDLE && steps > 2)) begin
         r = $urandom_range(0, 99);
         if (gst_phase == hcg_pkg::PH_FIRING && gst_action == hcg_pkg::ACT_REBOOT && r < 25) begin
            send_request(hcg_pkg::KIND_CLEAR, 3'($urandom), 1'($urandom), $urandom);
         end else if (r < 4) begin
            send_request(hcg_pkg::KIND_END, 3'($urandom), 1'($urandom), $urandom);
         end else if (r < 6) begin
            send_request(hcg_pkg::KIND_START, 3'($urandom), 1'($urandom), $urandom);
         end else if (r < 7) begin
            send_request(hcg_pkg::KIND_CLEAR, 3'($urandom), 1'($urandom), $urandom);
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0)
               clock_ms = $urandom;
            else if (r > 1)
               clock_ms += (r < 5) ? $urandom_range(0, span) : $urandom_range(0, span / 6 + 1);
            send_request(hcg_pkg::KIND_TICK, 3'($urandom), 1'($urandom), clock_ms);
         end
         steps++;
      end
   endtask

   task automatic test_reset_defaults();
      logic [31:0] t0;
      t0 = 32'hFFFF_FF00;
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, 32'd0);
      send_request(hcg_pkg::KIND_END, hcg_pkg::BTN_SELECT, 1'b0, 32'd0);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_UP, 1'b1, 32'd0);
      send_request(hcg_pkg::KIND_START, 3'd7, 1'b1, 32'hFFFF_FFFF);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_SELECT, 1'b0, 32'd0);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_SELECT, 1'b1, 32'd0);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd500);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd2000);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd3499);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd3500);
      send_request(hcg_pkg::KIND_END, hcg_pkg::BTN_SELECT, 1'b0, 32'd0);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd4499);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd4500);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, t0 + 32'd4501);
   endtask

   // Shortest timings, a key map with one code above the valid range, a
   // reboot that stays in firing until cleared, and an abort in preroll.
   task automatic test_keymap_and_wrap();
      apply_settings(16'd0, 16'd1, 16'd0, hcg_pkg::ACT_REBOOT, ACT_PAUSE, ACT_DISPLAY_OFF, 3'd7);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_RIGHT, 1'b1, 32'd0);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_UP, 1'b0, 32'd0);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_UP, 1'b1, 32'd0);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, 32'hFFFF_FFFF);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, 32'd0);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, 32'h7FFF_FFFF);
      send_request(hcg_pkg::KIND_CLEAR, 3'd7, 1'b1, 32'hFFFF_FFFF);
      send_request(hcg_pkg::KIND_START, hcg_pkg::BTN_DOWN, 1'b1, 32'd0);
      send_request(hcg_pkg::KIND_END, hcg_pkg::BTN_DOWN, 1'b1, 32'd0);
      send_request(hcg_pkg::KIND_TICK, hcg_pkg::BTN_SELECT, 1'b0, 32'd5);
   endtask

   task automatic test_random_gestures();
      int target;
      int per_setting;
      per_setting = RANDOM_ITEMS / SETTING_COUNT;
      for (int k = 0; k < SETTING_COUNT; k++) begin
         case (k)
            0: apply_settings(16'd0, 16'd1, 16'd0, random_key_action(), random_key_action(),
                              random_key_action(), random_key_action());
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, random_key_action(),
                              random_key_action(), random_key_action(), random_key_action());
            2: apply_settings(hcg_pkg::PREROLL_RESET, hcg_pkg::BAR_RESET, hcg_pkg::DONE_RESET,
                              hcg_pkg::ACT_PROG, hcg_pkg::ACT_REBOOT, ACT_PAUSE,
                              ACT_DISPLAY_OFF);
            default: begin
               if (k % 2 == 0)
                  apply_settings(16'($urandom_range(0, 40)), 16'($urandom_range(1, 60)),
                                 16'($urandom_range(0, 40)), random_key_action(),
                                 random_key_action(), random_key_action(),
                                 random_key_action());
               else
                  apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                                 16'($urandom_range(0, 65535)), random_key_action(),
                                 random_key_action(), random_key_action(),
                                 random_key_action());
            end
         endcase
         stall_mode = k % 3;
         gap_max = (k % 4 == 1) ? 0 : 2 + 3 * (k % 3);
         clock_ms = (k % 2 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;
         target = requests_sent + per_setting;
         while (requests_sent < target)
            run_gesture();
      end
   endtask

   always @(negedge clock) begin
      case (stall_mode)
         STALL_NONE: rsp_ready = 1'b1;
         STALL_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left != 0) begin
               rsp_ready = 1'b0;
               stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 14);
               rsp_ready = 1'b0;
            end else begin
               rsp_ready = 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      gesture_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (status_q.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                      responses_seen));
         end else begin
            want = status_q.pop_front();
            if (rsp_phase !== want.phase)
               report_mismatch($sformatf("response %0d phase %0d, expected %0d",
                                         responses_seen, rsp_phase, want.phase));
            if (rsp_current_action !== want.current_action)
               report_mismatch($sformatf("response %0d current_action %0d, expected %0d",
                                         responses_seen, rsp_current_action,
                                         want.current_action));
            if (rsp_fired_action !== want.fired_action)
               report_mismatch($sformatf("response %0d fired_action %0d, expected %0d",
                                         responses_seen, rsp_fired_action, want.fired_action));
            if (rsp_bar_fraction !== want.bar_fraction)
               report_mismatch($sformatf("response %0d bar_fraction %0d, expected %0d",
                                         responses_seen, rsp_bar_fraction, want.bar_fraction));
            if (rsp_seconds_left !== want.seconds_left)
               report_mismatch($sformatf("response %0d seconds_left %0d, expected %0d",
                                         responses_seen, rsp_seconds_left, want.seconds_left));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d responses outstanding", status_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      stall_mode = STALL_RANDOM;
      gap_max = 3;
      test_reset_defaults();
      test_keymap_and_wrap();
      test_random_gestures();
      drain_responses();
      repeat (40) @(posedge clock);
      if (status_q.size() != 0)
         report_mismatch($sformatf("%0d expected responses never arrived", status_q.size()));
      $display("Sent %0d requests across %0d register writes, %0d responses checked.",
               requests_sent, register_writes, responses_seen);
      $display("Gestures fired %0d, aborted %0d, partly emptied bar seen %0d times.",
               fired_count, abort_count, partial_bar_count);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
